@@ rtl/twpf_pkg.sv @@
// ----------------------------------------------------------------------------
// twpf_pkg
// Shared constants and register codes for the time window packet FIFO.
// ----------------------------------------------------------------------------
package twpf_pkg;

  // timestamp and configuration widths
  localparam int TIME_W   = 63;
  localparam int CFG_W    = 32;
  localparam int APB_AW   = 3;

  // nanoseconds per millisecond, width of the span threshold
  localparam int NS_PER_MS = 1000000;
  localparam int NSMS_W    = 20;
  localparam int THR_W     = CFG_W + 1 + NSMS_W;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] MAX_SPAN_RST   = 32'd10000;
  localparam logic [CFG_W-1:0] BYTE_LIMIT_RST = 32'd0;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_MAX_SPAN   = 1'b0,
    REG_BYTE_LIMIT = 1'b1
  } reg_idx_t;

  // input op codes
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

endpackage

@@ rtl/time_window_packet_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// time_window_packet_fifo_unit
// Sliding time window FIFO of packet descriptors with a running byte total.
// ----------------------------------------------------------------------------
// A push stores a timestamp and a byte size, then drops the oldest entries
// while more than one is held and either the span (newest minus oldest
// timestamp, in whole ms) exceeds max_span_ms or a nonzero byte_limit is
// exceeded; a clear empties the store. Each item yields one result beat.
// A push into a full store first drops the oldest entry. Evictions are paced
// by the single read port of the entry memories: each eviction reads the next
// oldest entry, and that read is registered. A new item is accepted while the
// previous result still waits in the output register. The entry memories
// need no clearing pass: only held entries are ever read.
// ----------------------------------------------------------------------------
module time_window_packet_fifo_unit
  import twpf_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int SIZE_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input channel
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_op,
  input  logic [TIME_W-1:0]                          in_time_ns,
  input  logic [SIZE_BITS-1:0]                       in_packet_bytes,
  // result channel
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [$clog2(DEPTH+1)-1:0]                 out_evicted_count,
  output logic [$clog2(DEPTH+1)-1:0]                 out_entry_count,
  output logic [SIZE_BITS+$clog2(DEPTH+1)-1:0]       out_byte_total,
  output logic                                       out_full_drop,
  // configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [APB_AW-1:0]                          paddr,
  input  logic [CFG_W-1:0]                           pwdata,
  output logic [CFG_W-1:0]                           prdata,
  output logic                                       pready
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int TOT_W = SIZE_BITS + CNT_W;
  localparam int CMP_W = (TOT_W > CFG_W) ? TOT_W : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROPF,
    ST_CHECK,
    ST_WAIT
  } state_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] max_span_r;
  logic [CFG_W-1:0] byte_limit_r;
  logic [THR_W-1:0] thr_r;
  reg_idx_t         reg_idx;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_span_r   <= MAX_SPAN_RST;
      byte_limit_r <= BYTE_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MAX_SPAN:   max_span_r   <= pwdata;
        REG_BYTE_LIMIT: byte_limit_r <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_SPAN:   prdata = max_span_r;
      REG_BYTE_LIMIT: prdata = byte_limit_r;
      default:        prdata = '0;
    endcase
  end

  // span over limit <=> diff >= (max_span_ms + 1) * 1e6
  always_ff @(posedge clk) begin
    thr_r <= THR_W'({1'b0, max_span_r} + 33'd1) * THR_W'(NS_PER_MS);
  end

  // --------------------------------------------------------------------------
  // control and entry state
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]      held_r, held_nxt;
  logic [TOT_W-1:0]      bytes_r, bytes_nxt;
  logic [CNT_W-1:0]      evict_r, evict_nxt;
  logic                  full_r, full_nxt;
  logic [TIME_W-1:0]     newest_r, newest_nxt;
  logic [SIZE_BITS-1:0]  size_in_r, size_in_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]      out_evict_r, out_evict_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic [TOT_W-1:0]      out_total_r, out_total_nxt;
  logic                  out_full_r, out_full_nxt;

  // memory ports
  logic                  mem_we;
  logic [AW-1:0]         wr_addr;
  logic [TIME_W-1:0]     wr_stamp;
  logic [SIZE_BITS-1:0]  wr_size;
  logic [AW-1:0]         rd_addr;
  logic [TIME_W-1:0]     stamp_q;
  logic [SIZE_BITS-1:0]  size_q;

  logic [TIME_W-1:0]     stamp_mem [DEPTH];
  logic [SIZE_BITS-1:0]  size_mem  [DEPTH];

  // entry memories, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
      size_mem[wr_addr]  <= wr_size;
    end
    stamp_q <= stamp_mem[rd_addr];
    size_q  <= size_mem[rd_addr];
  end

  // ring index arithmetic
  logic [AW-1:0] head_inc;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;

  assign head_inc = (head_r == AW'(DEPTH-1)) ? '0 : head_r + 1'b1;
  assign tail_sum = {1'b0, head_r} + {1'b0, held_r[AW-1:0]};
  assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(DEPTH)) : tail_sum[AW-1:0];

  // eviction conditions against the oldest entry just read
  logic [TIME_W:0] diff;
  logic            span_over;
  logic            bytes_over;
  logic            drop_more;
  logic            can_load;

  assign diff       = {1'b0, newest_r} - {1'b0, stamp_q};
  assign span_over  = !diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_W'(thr_r));
  assign bytes_over = (byte_limit_r != '0) &&
                      (CMP_W'(bytes_r) > CMP_W'(byte_limit_r));
  assign drop_more  = (held_r > CNT_W'(1)) && (span_over || bytes_over);
  assign can_load   = !out_valid_r || out_ready;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    held_nxt      = held_r;
    bytes_nxt     = bytes_r;
    evict_nxt     = evict_r;
    full_nxt      = full_r;
    newest_nxt    = newest_r;
    size_in_nxt   = size_in_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_evict_nxt = out_evict_r;
    out_count_nxt = out_count_r;
    out_total_nxt = out_total_r;
    out_full_nxt  = out_full_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    wr_addr       = tail;
    wr_stamp      = in_time_ns;
    wr_size       = in_packet_bytes;
    rd_addr       = head_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          newest_nxt  = in_time_ns;
          size_in_nxt = in_packet_bytes;
          evict_nxt   = '0;
          full_nxt    = 1'b0;
          if (op_t'(in_op) == OP_CLEAR) begin
            evict_nxt = held_r;
            head_nxt  = '0;
            held_nxt  = '0;
            bytes_nxt = '0;
            state_nxt = ST_WAIT;
          end else if (held_r == CNT_W'(DEPTH)) begin
            // full: read the oldest size first
            state_nxt = ST_DROPF;
          end else begin
            mem_we    = 1'b1;
            held_nxt  = held_r + 1'b1;
            bytes_nxt = bytes_r + TOT_W'(in_packet_bytes);
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_DROPF: begin
        // forced drop, new entry lands in the freed slot
        mem_we    = 1'b1;
        wr_addr   = head_r;
        wr_stamp  = newest_r;
        wr_size   = size_in_r;
        bytes_nxt = bytes_r - TOT_W'(size_q) + TOT_W'(size_in_r);
        head_nxt  = head_inc;
        evict_nxt = CNT_W'(1);
        full_nxt  = 1'b1;
        rd_addr   = head_inc;
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        if (drop_more) begin
          bytes_nxt = bytes_r - TOT_W'(size_q);
          head_nxt  = head_inc;
          held_nxt  = held_r - 1'b1;
          evict_nxt = evict_r + 1'b1;
          rd_addr   = head_inc;
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_evict_nxt = evict_r;
          out_count_nxt = held_r;
          out_total_nxt = bytes_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end

      ST_WAIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_evict_nxt = evict_r;
          out_count_nxt = held_r;
          out_total_nxt = bytes_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      held_r      <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
    evict_r     <= evict_nxt;
    full_r      <= full_nxt;
    newest_r    <= newest_nxt;
    size_in_r   <= size_in_nxt;
    out_evict_r <= out_evict_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_evicted_count = out_evict_r;
  assign out_entry_count   = out_count_r;
  assign out_byte_total    = out_total_r;
  assign out_full_drop     = out_full_r;

endmodule

@@ tb/time_window_packet_fifo_unit_tb.sv @@
// ----------------------------------------------------------------------------
// time_window_packet_fifo_unit_tb
// Self-checking bench for the sliding time window packet FIFO.
// ----------------------------------------------------------------------------
// Drives push and clear beats through a valid/ready input channel, programs
// the span and byte limits over the APB port, and checks every result beat
// against a queue-based model of the window. Covers window edges, backwards
// stamps, byte limits (including a lowered limit), the full store, output
// back-pressure and randomized phases over a range of limit settings.
// ----------------------------------------------------------------------------
module time_window_packet_fifo_unit_tb;
  import twpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int SIZE_BITS   = 24;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int TOT_W       = SIZE_BITS + CNT_W;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BEATS = 6;
  localparam logic [TIME_W-1:0] NS_MS    = TIME_W'(NS_PER_MS);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0] evicted;
    logic [CNT_W-1:0] entries;
    logic [TOT_W-1:0] byte_sum;
    logic             full;
  } window_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_op;
  logic [TIME_W-1:0]      in_time_ns;
  logic [SIZE_BITS-1:0]   in_packet_bytes;
  logic                   out_valid;
  logic                   out_ready;
  logic [CNT_W-1:0]       out_evicted_count;
  logic [CNT_W-1:0]       out_entry_count;
  logic [TOT_W-1:0]       out_byte_total;
  logic                   out_full_drop;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [CFG_W-1:0]       pwdata;
  logic [CFG_W-1:0]       prdata;
  logic                   pready;

  // window model state
  logic [TIME_W-1:0]      held_stamps[$];
  logic [SIZE_BITS-1:0]   held_sizes[$];
  logic [TOT_W-1:0]       held_total = '0;
  logic [CFG_W-1:0]       span_limit_ms = MAX_SPAN_RST;
  logic [CFG_W-1:0]       byte_cap = BYTE_LIMIT_RST;

  window_result_t         expected_results[$];
  int                     fail_count = 0;
  int                     cycle_count = 0;
  int                     sent_count = 0;
  int                     recv_count = 0;
  bit                     idle_en = 1'b1;
  bit                     hold_req = 1'b0;
  logic [TIME_W-1:0]      cur_time = '0;

  time_window_packet_fifo_unit #(
    .DEPTH     (DEPTH),
    .SIZE_BITS (SIZE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_time_ns        (in_time_ns),
    .in_packet_bytes   (in_packet_bytes),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_evicted_count (out_evicted_count),
    .out_entry_count   (out_entry_count),
    .out_byte_total    (out_byte_total),
    .out_full_drop     (out_full_drop),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Window model
  // ---------------------------------------------------------------------------
  function automatic void drop_oldest();
    held_total = held_total - TOT_W'(held_sizes[0]);
    held_stamps.delete(0);
    held_sizes.delete(0);
  endfunction

  // span in whole ms between oldest and newest; backwards stamps never exceed
  function automatic bit window_too_wide();
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] newest;
    oldest = held_stamps[0];
    newest = held_stamps[$];
    if (newest < oldest) return 1'b0;
    return ((newest - oldest) / NS_MS) > TIME_W'(span_limit_ms);
  endfunction

  function automatic window_result_t apply_beat(op_t op, logic [TIME_W-1:0] t,
                                                logic [SIZE_BITS-1:0] b);
    window_result_t r;
    r = '0;
    if (op == OP_CLEAR) begin
      r.evicted = CNT_W'(held_stamps.size());
      held_stamps.delete();
      held_sizes.delete();
      held_total = '0;
    end else begin
      if (held_stamps.size() >= DEPTH) begin
        drop_oldest();
        r.evicted = r.evicted + 1'b1;
        r.full    = 1'b1;
      end
      held_stamps.insert(held_stamps.size(), t);
      held_sizes.insert(held_sizes.size(), b);
      held_total = held_total + TOT_W'(b);
      while (held_stamps.size() > 1 &&
             (window_too_wide() || (byte_cap != '0 && held_total > TOT_W'(byte_cap)))) begin
        drop_oldest();
        r.evicted = r.evicted + 1'b1;
      end
    end
    r.entries  = CNT_W'(held_stamps.size());
    r.byte_sum = held_total;
    return r;
  endfunction

  // predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_results.insert(expected_results.size(),
                              apply_beat(op_t'(in_op), in_time_ns, in_packet_bytes));
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && out_valid && out_ready) begin
      recv_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("result beat with no prediction pending");
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_evicted_count !== want.evicted) begin
          fail_count++;
          $error("evicted_count: expected %0d, got %0d", want.evicted, out_evicted_count);
        end
        if (out_entry_count !== want.entries) begin
          fail_count++;
          $error("entry_count: expected %0d, got %0d", want.entries, out_entry_count);
        end
        if (out_byte_total !== want.byte_sum) begin
          fail_count++;
          $error("byte_total: expected %0d, got %0d", want.byte_sum, out_byte_total);
        end
        if (out_full_drop !== want.full) begin
          fail_count++;
          $error("full_drop: expected %0d, got %0d", want.full, out_full_drop);
        end
      end
    end
  end

  // result receiver: random stalls, or one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = idle_en ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_beat(input op_t op, input logic [TIME_W-1:0] t,
                           input logic [SIZE_BITS-1:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_time_ns      <= t;
    in_packet_bytes <= b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // stop offering and wait for every sent beat's result
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (recv_count != sent_count) @(posedge clk);
  endtask

  // one APB transfer; psel stays high so transfers can go back to back
  task automatic apb_access(input logic wr, input reg_idx_t idx,
                            input logic [CFG_W-1:0] wdata,
                            output logic [CFG_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rdata = prdata;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [CFG_W-1:0] rd);
    logic [CFG_W-1:0] want;
    want = (idx == REG_MAX_SPAN) ? span_limit_ms : byte_cap;
    if (rd !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d",
             (idx == REG_MAX_SPAN) ? "max_span_ms" : "byte_limit", want, rd);
    end
  endtask

  // write both limits, then read them back
  task automatic program_window(input logic [CFG_W-1:0] span,
                                input logic [CFG_W-1:0] limit);
    logic [CFG_W-1:0] rd;
    apb_access(1'b1, REG_MAX_SPAN, span, rd);
    apb_access(1'b1, REG_BYTE_LIMIT, limit, rd);
    span_limit_ms = span;
    byte_cap      = limit;
    apb_access(1'b0, REG_MAX_SPAN, '0, rd);
    check_reg(REG_MAX_SPAN, rd);
    apb_access(1'b0, REG_BYTE_LIMIT, '0, rd);
    check_reg(REG_BYTE_LIMIT, rd);
    apb_release();
  endtask

  function automatic logic [TIME_W-1:0] rand_stamp();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    logic [CFG_W-1:0] rd;
    apb_access(1'b0, REG_MAX_SPAN, '0, rd);
    check_reg(REG_MAX_SPAN, rd);
    apb_access(1'b0, REG_BYTE_LIMIT, '0, rd);
    check_reg(REG_BYTE_LIMIT, rd);
    apb_release();
  endtask

  // span edges at the reset limit, backwards stamp, extreme stamp, clears
  task automatic test_window_span();
    send_beat(OP_CLEAR, TIME_MAX, '1);
    send_beat(OP_PUSH, '0, '0);
    send_beat(OP_PUSH, 63'd10000 * NS_MS, '1);
    send_beat(OP_PUSH, 63'd10001 * NS_MS - 1, 24'd1);
    send_beat(OP_PUSH, 63'd10001 * NS_MS, 24'd2);
    send_beat(OP_PUSH, 63'd5, 24'd3);
    send_beat(OP_PUSH, TIME_MAX, '1);
    send_beat(OP_CLEAR, '0, '0);
    wait_drain();
  endtask

  // byte limit eviction, lone oversize entry, and a lowered limit
  task automatic test_byte_limit();
    program_window(32'd10000, 32'd100);
    send_beat(OP_PUSH, 63'd0, 24'd60);
    send_beat(OP_PUSH, 63'd1, 24'd60);
    send_beat(OP_PUSH, 63'd2, 24'd200);
    send_beat(OP_PUSH, 63'd3, 24'd0);
    send_beat(OP_PUSH, 63'd4, 24'd100);
    send_beat(OP_PUSH, 63'd5, 24'd1);
    send_beat(OP_CLEAR, 63'd6, 24'd0);
    wait_drain();
    program_window(32'd10000, 32'd0);
    for (int i = 0; i < 6; i++) send_beat(OP_PUSH, 63'(10 + i), 24'd1000);
    wait_drain();
    // lower limit applies at the next push
    program_window(32'd10000, 32'd2500);
    send_beat(OP_PUSH, 63'd16, 24'd0);
    send_beat(OP_CLEAR, 63'd17, 24'd0);
    wait_drain();
  endtask

  // zero span: same ms kept, next ms evicts
  task automatic test_zero_span();
    program_window(32'd0, 32'd0);
    send_beat(OP_PUSH, 63'd100 * NS_MS, 24'd7);
    send_beat(OP_PUSH, 63'd101 * NS_MS - 1, 24'd8);
    send_beat(OP_PUSH, 63'd101 * NS_MS, 24'd9);
    wait_drain();
  endtask

  // fill past DEPTH, then a far stamp that drops the whole store
  task automatic test_full_store();
    program_window(32'd10000, 32'd0);
    idle_en = 1'b0;
    send_beat(OP_CLEAR, '0, '0);
    for (int i = 0; i < DEPTH + 4; i++)
      send_beat(OP_PUSH, 63'(1000 + i), SIZE_BITS'($urandom));
    send_beat(OP_PUSH, 63'd1000 + 63'd20000 * NS_MS, SIZE_BITS'($urandom));
    send_beat(OP_CLEAR, '0, '0);
    wait_drain();
    idle_en = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering; then sender pauses
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      cur_time = cur_time + NS_MS;
      send_beat(OP_PUSH, cur_time, SIZE_BITS'($urandom_range(0, 255)));
    end
    wait_drain();
    for (int i = 0; i < 10; i++) begin
      cur_time = cur_time + 63'($urandom_range(0, 999999));
      send_beat(OP_PUSH, cur_time, SIZE_BITS'($urandom));
    end
    wait_drain();
    idle_en = 1'b1;
  endtask

  // random phases, each under its own limit setting
  task automatic test_random();
    int                   roll;
    int unsigned          ms_range;
    logic [CFG_W-1:0]     span;
    logic [CFG_W-1:0]     limit;
    logic [SIZE_BITS-1:0] b;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       begin span = 32'd5;          limit = 32'd0;         end
        1:       begin span = 32'd0;          limit = 32'd0;         end
        2:       begin span = 32'd20;         limit = 32'd50000000;  end
        3:       begin span = 32'hFFFF_FFFF;  limit = 32'd0;         end
        4:       begin span = 32'd3;          limit = 32'd1;         end
        5:       begin span = 32'd10000;      limit = 32'hFFFF_FFFF; end
        6:       begin span = 32'd2;          limit = 32'd20000000;  end
        default: begin span = 32'd50;         limit = 32'd200000000; end
      endcase
      program_window(span, limit);
      idle_en  = (ph % 3) != 2;
      ms_range = (span > 32'd1000) ? 1000 : int'(span);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        roll = $urandom_range(0, 99);
        b    = SIZE_BITS'($urandom >> $urandom_range(8, 31));
        if (roll < 3) begin
          send_beat(OP_CLEAR, rand_stamp(), b);
        end else if (roll < 8) begin
          send_beat(OP_PUSH, cur_time - TIME_W'($urandom), b);
        end else if (roll < 12) begin
          send_beat(OP_PUSH, rand_stamp(), b);
        end else begin
          // mostly a steadily advancing clock near the span limit
          cur_time = cur_time + TIME_W'($urandom_range(0, 2 * ms_range + 2)) * NS_MS
                     + TIME_W'($urandom_range(0, 999999));
          send_beat(OP_PUSH, cur_time, b);
        end
      end
      wait_drain();
    end
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op           <= OP_PUSH;
    in_time_ns      <= '0;
    in_packet_bytes <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_window_span();
    test_byte_limit();
    test_zero_span();
    test_full_store();
    test_backpressure();
    test_random();

    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
